// File: hdl/ccus_pkg.sv
// Shared types and constants for the cycle count to microseconds unit.
// No dependencies; used by ccus_div and cycle_count_to_microseconds_unit.
package ccus_pkg;

    localparam int RAW_W      = 32;
    localparam int TOTAL_W    = 64;
    localparam int RATE_W     = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int OUT_DATA_W = 2 * TOTAL_W + 2 * RATE_W;

    localparam int MICROS_W   = 20;
    localparam logic [MICROS_W-1:0] MICROS_PER_SECOND = MICROS_W'(1000000);

    localparam int PROD_W      = RAW_W + MICROS_W;
    localparam int DIV_NUM_W   = PROD_W + 1;
    localparam int DIV_COUNT_W = $clog2(DIV_NUM_W);

    localparam logic [CFG_INDEX_W-1:0] REG_TICK_RATE_HZ = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_EPOCH_ORIGIN = CFG_INDEX_W'(1);

    localparam logic HEALTH_OK      = 1'b0;
    localparam logic HEALTH_INVALID = 1'b1;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
        logic [RATE_W-1:0]    rem;
    } div_out_t;

endpackage

// File: hdl/cycle_count_to_microseconds_unit.sv
// Top level: extends a 32-bit cycle counter to 64 bits and converts it to microseconds.
// Depends on ccus_pkg and ccus_div.
//
// Usage:
//   s_* carries one raw counter sample per transaction (s_tdata = raw_cycles).
//   m_* returns one result per sample: m_tdata holds cycles_total, micros_total,
//   rate_echo and origin_echo; m_tuser holds health (0 ok, 1 invalid).
//   cfg_we/cfg_index/cfg_data write tick_rate_hz (index 0) or epoch_origin
//   (index 1); write only while no sample is in flight.
// Sequence:
//   A normal sample is taken into the delta register, multiplied by 10^6 in the
//   multiply step, divided by tick_rate_hz in the restoring divider (one
//   quotient bit per cycle) and added to the totals before the finish step
//   loads the output register. The first sample and samples on an invalid clock
//   go straight to the finish step. s_tready is high only while the sequencer is
//   idle, so one sample is in work; a new one is taken only after the finish step.
// Reset: all totals, the baseline flag, rate and origin clear to zero.
// Stall: the finished result sits in the output register; a new sample can be
//   accepted meanwhile, and the next result waits until the old one is taken.
module cycle_count_to_microseconds_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ccus_pkg::RAW_W-1:0]        s_tdata,   // raw_cycles[31:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // cycles_total[63:0], micros_total[127:64], rate_echo[159:128], origin_echo[191:160]
    output logic [ccus_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tuser,   // health[0]
    input  logic                              cfg_we,
    input  logic [ccus_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ccus_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ccus_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t state_reg;

    logic [RATE_W-1:0]  tick_rate_reg;
    logic [RATE_W-1:0]  epoch_origin_reg;
    logic               rate_rejected_reg;

    logic [TOTAL_W-1:0] cycles_acc_reg;
    logic [TOTAL_W-1:0] micros_acc_reg;
    logic [RATE_W-1:0]  frac_rem_reg;
    logic [RAW_W-1:0]   prev_raw_reg;
    logic               baseline_reg;
    logic [RAW_W-1:0]   delta_reg;
    logic               health_reg;

    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_health_reg;
    logic                  out_valid_reg;

    logic                 accept;
    logic                 clock_invalid;
    logic                 div_start;
    logic [PROD_W-1:0]    product;
    logic [DIV_NUM_W-1:0] div_num;
    div_out_t             div_res;

    assign s_tready      = (state_reg == ST_IDLE);
    assign accept        = s_tvalid && s_tready;
    assign clock_invalid = rate_rejected_reg || (tick_rate_reg == '0);
    assign div_start     = (state_reg == ST_MUL);

    assign product = delta_reg * MICROS_PER_SECOND;
    assign div_num = {1'b0, product} + {{(DIV_NUM_W-RATE_W){1'b0}}, frac_rem_reg};

    ccus_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (tick_rate_reg),
        .result (div_res)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_rate_reg     <= '0;
            epoch_origin_reg  <= '0;
            rate_rejected_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TICK_RATE_HZ:
                begin
                    if (cfg_data[RATE_W-1:0] != '0)
                    begin
                        if (baseline_reg && (cfg_data[RATE_W-1:0] != tick_rate_reg))
                        begin
                            rate_rejected_reg <= 1'b1;
                        end
                        else
                        begin
                            tick_rate_reg     <= cfg_data[RATE_W-1:0];
                            rate_rejected_reg <= 1'b0;
                        end
                    end
                end
                REG_EPOCH_ORIGIN:
                begin
                    epoch_origin_reg <= cfg_data[RATE_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // sequencer, state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cycles_acc_reg <= '0;
            micros_acc_reg <= '0;
            frac_rem_reg   <= '0;
            prev_raw_reg   <= '0;
            baseline_reg   <= 1'b0;
            delta_reg      <= '0;
            health_reg     <= HEALTH_OK;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_health_reg <= HEALTH_OK;
        end
        else
        begin
            // in ST_FINISH the output register is reloaded instead
            if (out_valid_reg && m_tready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (clock_invalid)
                        begin
                            health_reg <= HEALTH_INVALID;
                            state_reg  <= ST_FINISH;
                        end
                        else if (!baseline_reg)
                        begin
                            cycles_acc_reg <= '0;
                            prev_raw_reg   <= s_tdata;
                            baseline_reg   <= 1'b1;
                            health_reg     <= HEALTH_OK;
                            state_reg      <= ST_FINISH;
                        end
                        else
                        begin
                            delta_reg    <= s_tdata - prev_raw_reg;
                            prev_raw_reg <= s_tdata;
                            health_reg   <= HEALTH_OK;
                            state_reg    <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_res.done)
                    begin
                        cycles_acc_reg <= cycles_acc_reg
                                        + {{(TOTAL_W-RAW_W){1'b0}}, delta_reg};
                        micros_acc_reg <= micros_acc_reg
                                        + {{(TOTAL_W-DIV_NUM_W){1'b0}}, div_res.quot};
                        frac_rem_reg   <= div_res.rem;
                        state_reg      <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_data_reg   <= {epoch_origin_reg, tick_rate_reg,
                                           micros_acc_reg, cycles_acc_reg};
                        out_health_reg <= health_reg;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_health_reg;

    a_invalid_holds_totals: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && clock_invalid) |=>
            (cycles_acc_reg == $past(cycles_acc_reg)) &&
            (micros_acc_reg == $past(micros_acc_reg)) &&
            (state_reg == ST_FINISH))
        else $error("invalid-clock transaction changed the totals");

    a_remainder_below_rate: assert property (@(posedge clk) disable iff (!rst_n)
        (frac_rem_reg != '0) |-> (frac_rem_reg < tick_rate_reg))
        else $error("carried remainder not below the tick rate");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide step");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result loaded outside the finish step");

endmodule

// File: hdl/ccus_div.sv
// Restoring divider, one quotient bit per cycle, for the microsecond conversion.
// Depends on ccus_pkg.
module ccus_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ccus_pkg::DIV_NUM_W-1:0] num,
    input  logic [ccus_pkg::RATE_W-1:0]    den,
    output ccus_pkg::div_out_t             result
);
    import ccus_pkg::*;

    logic [DIV_NUM_W-1:0]   work_reg;
    logic [RATE_W-1:0]      rem_reg;
    logic [RATE_W-1:0]      den_reg;
    logic [DIV_COUNT_W-1:0] count_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic [RATE_W:0]   trial;
    logic [RATE_W+1:0] diff;
    logic              qbit;
    logic [RATE_W-1:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, work_reg[DIV_NUM_W-1]};
        diff     = {1'b0, trial} - {2'b00, den_reg};
        qbit     = ~diff[RATE_W+1];
        rem_next = qbit ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= DIV_COUNT_W'(DIV_NUM_W - 1);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[DIV_NUM_W-2:0], qbit};
            rem_reg  <= rem_next;
        end
    end

    assign result.done = done_reg;
    assign result.quot = work_reg;
    assign result.rem  = rem_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    a_no_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider busy while reporting done");

endmodule

// File: test/cycle_count_to_microseconds_unit_tb.sv
// Self-checking testbench for cycle_count_to_microseconds_unit: directed table, then random phases.
// Depends on ccus_pkg and the unit; checks results against table rows or an in-bench predictor.
`timescale 1ns / 100ps

module cycle_count_to_microseconds_unit_tb;

    import ccus_pkg::*;

    localparam int          GAP_MAX       = 14;
    localparam int          RANDOM_ITEMS  = 400;
    localparam int          SETTLE_CYCLES = 64;
    localparam logic [63:0] USEC_PER_SEC  = 64'd1_000_000;

    typedef struct packed {
        logic [TOTAL_W-1:0] cycles;
        logic [TOTAL_W-1:0] micros;
        logic [RATE_W-1:0]  rate;
        logic [RATE_W-1:0]  origin;
        logic               health;
    } clock_report_t;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

    typedef struct {
        row_kind_t               kind;
        logic [CFG_INDEX_W-1:0]  index;
        logic [CFG_DATA_W-1:0]   value;
        bit                      typed;
        clock_report_t           want;
    } stim_row_t;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [RAW_W-1:0]        s_tdata   = '0;   // raw_cycles[31:0]
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    // cycles_total[63:0], micros_total[127:64], rate_echo[159:128], origin_echo[191:160]
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic                    m_tuser;          // health[0]
    logic                    cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    bit                      no_idle    = 1'b0;
    int                      mismatches = 0;
    clock_report_t           pending_reports[$];
    stim_row_t               stim_rows[$];

    // predictor state
    logic [RATE_W-1:0]       pred_rate     = '0;
    logic [RATE_W-1:0]       pred_origin   = '0;
    logic [TOTAL_W-1:0]      pred_micros   = '0;
    logic [RATE_W-1:0]       pred_frac     = '0;
    logic [TOTAL_W-1:0]      pred_cycles   = '0;
    logic [RAW_W-1:0]        pred_prev     = '0;
    logic                    pred_baseline = 1'b0;
    logic                    pred_rejected = 1'b0;

    cycle_count_to_microseconds_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void update_register(input logic [CFG_INDEX_W-1:0] index,
                                            input logic [CFG_DATA_W-1:0] value);
        if (index == REG_TICK_RATE_HZ)
        begin
            if (value != '0)
            begin
                // rate is locked once a baseline exists
                if (pred_baseline && value != pred_rate)
                    pred_rejected = 1'b1;
                else
                begin
                    pred_rate     = value;
                    pred_rejected = 1'b0;
                end
            end
        end
        else if (index == REG_EPOCH_ORIGIN)
            pred_origin = value;
    endfunction

    function automatic clock_report_t convert_sample(input logic [RAW_W-1:0] raw);
        logic [RAW_W-1:0]   delta;
        logic [TOTAL_W-1:0] scaled;
        clock_report_t      r;
        logic               health;
        if (pred_rejected || pred_rate == '0)
            health = HEALTH_INVALID;
        else
        begin
            health = HEALTH_OK;
            if (pred_baseline)
            begin
                delta        = raw - pred_prev;
                scaled       = 64'(delta) * USEC_PER_SEC + 64'(pred_frac);
                pred_cycles  = pred_cycles + 64'(delta);
                pred_micros  = pred_micros + scaled / 64'(pred_rate);
                pred_frac    = 32'(scaled % 64'(pred_rate));
            end
            else
                pred_cycles = '0;
            pred_prev     = raw;
            pred_baseline = 1'b1;
        end
        r.cycles = pred_cycles;
        r.micros = pred_micros;
        r.rate   = pred_rate;
        r.origin = pred_origin;
        r.health = health;
        return r;
    endfunction

    function automatic clock_report_t make_report(input logic [63:0] cycles,
                                                  input logic [63:0] micros,
                                                  input logic [31:0] rate,
                                                  input logic [31:0] origin,
                                                  input logic health);
        clock_report_t r;
        r.cycles = cycles;
        r.micros = micros;
        r.rate   = rate;
        r.origin = origin;
        r.health = health;
        return r;
    endfunction

    function automatic void add_write(input logic [CFG_INDEX_W-1:0] index,
                                      input logic [CFG_DATA_W-1:0] value);
        stim_row_t row;
        row.kind  = ROW_WRITE;
        row.index = index;
        row.value = value;
        row.typed = 1'b0;
        row.want  = '0;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_sample(input logic [RAW_W-1:0] raw, input bit typed,
                                       input clock_report_t want);
        stim_row_t row;
        row.kind  = ROW_SAMPLE;
        row.index = '0;
        row.value = raw;
        row.typed = typed;
        row.want  = want;
        stim_rows.push_back(row);
    endfunction

    function automatic void check_field(input string name, input logic [63:0] expected,
                                        input logic [63:0] actual);
        if (actual !== expected)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, name, expected, actual);
            mismatches++;
        end
    endfunction

    task automatic send_sample(input logic [RAW_W-1:0] raw, input bit typed,
                               input clock_report_t want);
        int            gap;
        clock_report_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        do @(posedge clk); while (!s_tready);
        predicted = convert_sample(raw);
        pending_reports.push_back(typed ? want : predicted);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        update_register(index, value);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // result side: random stalls, checks each transaction against the oldest prediction
    initial
    begin
        int            stall;
        clock_report_t got;
        clock_report_t want;
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            got.cycles = m_tdata[63:0];
            got.micros = m_tdata[127:64];
            got.rate   = m_tdata[159:128];
            got.origin = m_tdata[191:160];
            got.health = m_tuser;
            if (pending_reports.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
                mismatches++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("cycles_total", want.cycles, got.cycles);
                check_field("micros_total", want.micros, got.micros);
                check_field("rate_echo", 64'(want.rate), 64'(got.rate));
                check_field("origin_echo", 64'(want.origin), 64'(got.origin));
                check_field("health", 64'(want.health), 64'(got.health));
            end
        end
    end

    initial
    begin
        clock_report_t     none;
        logic [RATE_W-1:0] bound_rate;
        logic [RATE_W-1:0] other_rate;
        logic [RAW_W-1:0]  raw_cursor;
        logic [RAW_W-1:0]  delta;
        int                sent;
        int                ops;
        int                phase_len;
        none = '0;
        case ($urandom_range(0, 4))
            0:       bound_rate = 32'd1;
            1:       bound_rate = 32'hFFFF_FFFF;
            2:       bound_rate = $urandom_range(1, 2000);
            3:       bound_rate = $urandom_range(999_000, 1_001_000);
            default: bound_rate = $urandom | 32'd1;
        endcase
        other_rate = (bound_rate == 32'd1) ? 32'd2 : 32'd1;

        add_write(REG_EPOCH_ORIGIN, 32'hFFFF_FFFF);
        // no rate bound yet: invalid, nothing moves
        add_sample(32'hFFFF_FFFF, 1'b1,
                   make_report(64'd0, 64'd0, 32'd0, 32'hFFFF_FFFF, HEALTH_INVALID));
        add_sample(32'h0000_0000, 1'b1,
                   make_report(64'd0, 64'd0, 32'd0, 32'hFFFF_FFFF, HEALTH_INVALID));
        add_write(REG_TICK_RATE_HZ, 32'd1);
        add_write(REG_TICK_RATE_HZ, 32'hFFFF_FFFF);
        add_write(REG_TICK_RATE_HZ, 32'd0);
        add_write(REG_TICK_RATE_HZ, bound_rate);
        // baseline
        add_sample(32'hFFFF_FFFF, 1'b1,
                   make_report(64'd0, 64'd0, bound_rate, 32'hFFFF_FFFF, HEALTH_OK));
        add_sample(32'hFFFF_FFFE, 1'b0, none);     // largest delta
        add_sample(32'hFFFF_FFFE, 1'b0, none);     // zero delta
        add_sample(32'h0000_0005, 1'b0, none);     // counter wrap
        add_sample(32'h8000_0000, 1'b0, none);
        add_write(REG_TICK_RATE_HZ, other_rate);   // rejected, clock invalid
        add_sample(32'h1234_5678, 1'b0, none);
        add_write(REG_TICK_RATE_HZ, 32'd0);        // ignored, still invalid
        add_sample(32'hAAAA_AAAA, 1'b0, none);
        add_write(REG_TICK_RATE_HZ, bound_rate);   // same value clears the mark
        add_write(REG_EPOCH_ORIGIN, 32'h0000_0000);
        add_sample(32'h9000_0000, 1'b0, none);
        add_sample(32'h5555_5555, 1'b0, none);
        add_sample(32'h0000_0000, 1'b0, none);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == ROW_WRITE)
            begin
                wait_idle();
                write_reg(stim_rows[i].index, stim_rows[i].value);
            end
            else
                send_sample(stim_rows[i].value, stim_rows[i].typed, stim_rows[i].want);
        end

        raw_cursor = 32'h0000_0000;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_idle();
            no_idle = ($urandom_range(0, 3) == 0);
            ops = $urandom_range(0, 3);
            repeat (ops)
            begin
                case ($urandom_range(0, 3))
                    0:       write_reg(REG_EPOCH_ORIGIN, $urandom);
                    1:       write_reg(REG_TICK_RATE_HZ, bound_rate);
                    2:       write_reg(REG_TICK_RATE_HZ, 32'd0);
                    default: write_reg(REG_TICK_RATE_HZ, $urandom);
                endcase
            end
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_TICK_RATE_HZ, bound_rate);
            phase_len = $urandom_range(5, 50);
            repeat (phase_len)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: delta = $urandom_range(0, 5000);
                    4, 5:       delta = $urandom_range(0, 32'h00FF_FFFF);
                    6, 7:       delta = $urandom;
                    8:          delta = 32'hFFFF_FFFF - $urandom_range(0, 100);
                    default:    delta = 32'd0;
                endcase
                raw_cursor = raw_cursor + delta;
                send_sample(raw_cursor, 1'b0, none);
                sent++;
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
hdl/ccus_pkg.sv
hdl/ccus_div.sv
hdl/cycle_count_to_microseconds_unit.sv
test/cycle_count_to_microseconds_unit_tb.sv
